>>> rtl/stok_pkg.sv
`timescale 1ns / 1ps

package stok_pkg;

	// Field widths of the text and token words.
	localparam int BYTE_W = 8;
	localparam int KIND_W = 6;
	localparam int FIELD_W = 16;
	localparam int ERR_W = 3;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_IDENT      = 6'd5;
	localparam logic [KIND_W-1:0] KIND_INT        = 6'd6;
	localparam logic [KIND_W-1:0] KIND_STR        = 6'd7;
	localparam logic [KIND_W-1:0] KIND_ERR        = 6'd4;
	localparam logic [KIND_W-1:0] KIND_COLON2     = 6'd8;
	localparam logic [KIND_W-1:0] KIND_ASSIGN     = 6'd9;
	localparam logic [KIND_W-1:0] KIND_EQ         = 6'd10;
	localparam logic [KIND_W-1:0] KIND_SEMI       = 6'd11;
	localparam logic [KIND_W-1:0] KIND_COMMA      = 6'd12;
	localparam logic [KIND_W-1:0] KIND_LPAREN     = 6'd13;
	localparam logic [KIND_W-1:0] KIND_RPAREN     = 6'd14;
	localparam logic [KIND_W-1:0] KIND_LBRACE     = 6'd15;
	localparam logic [KIND_W-1:0] KIND_RBRACE     = 6'd16;
	localparam logic [KIND_W-1:0] KIND_EQEQ       = 6'd17;
	localparam logic [KIND_W-1:0] KIND_NE         = 6'd18;
	localparam logic [KIND_W-1:0] KIND_GT         = 6'd19;
	localparam logic [KIND_W-1:0] KIND_LT         = 6'd20;
	localparam logic [KIND_W-1:0] KIND_GE         = 6'd21;
	localparam logic [KIND_W-1:0] KIND_LE         = 6'd22;
	localparam logic [KIND_W-1:0] KIND_PLUS       = 6'd28;
	localparam logic [KIND_W-1:0] KIND_MINUS      = 6'd29;
	localparam logic [KIND_W-1:0] KIND_STAR       = 6'd30;
	localparam logic [KIND_W-1:0] KIND_END        = 6'd33;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_DIGITID = 3'd1;
	localparam logic [ERR_W-1:0] ERR_COLON   = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BANG    = 3'd3;
	localparam logic [ERR_W-1:0] ERR_INVALID = 3'd4;

	// Characters with a meaning of their own.
	localparam logic [BYTE_W-1:0] CH_NUL        = 8'h00;
	localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_QUOTE      = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_EQUAL      = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_BANG       = 8'h21;
	localparam logic [BYTE_W-1:0] CH_LESS       = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GREATER    = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_SEMI       = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_COMMA      = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LPAREN     = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN     = 8'h29;
	localparam logic [BYTE_W-1:0] CH_LBRACE     = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE     = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;

	// Keyword spelling (proc, return, if, else), padded with zeros.
	localparam int KW_MAX = 4;
	localparam logic [BYTE_W-1:0] KW_TEXT [KW_MAX][8] = '{
		'{8'h70, 8'h72, 8'h6F, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_MAX] = '{3'd4, 3'd6, 3'd2, 3'd4};

	// One token word as it is queued for output.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic [ERR_W-1:0]   err;
		logic               last;
	} result_t;

	function automatic result_t mk_res(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] start,
			logic [FIELD_W-1:0] length, logic [ERR_W-1:0] err);
		result_t r;
		r.kind = kind;
		r.start = start;
		r.length = length;
		r.err = err;
		r.last = 1'b0;
		return r;
	endfunction

	// Character classes.
	function automatic logic is_space(logic [BYTE_W-1:0] b);
		return b inside {[8'd9:8'd13], 8'd32};
	endfunction

	function automatic logic is_alpha(logic [BYTE_W-1:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_digit(logic [BYTE_W-1:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(logic [BYTE_W-1:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
	endfunction

endpackage

>>> rtl/stok_byte_if.sv
`timescale 1ns / 1ps

// Text channel: one source byte per word.
interface stok_byte_if;
	logic                          valid;
	logic                          ready;
	logic [stok_pkg::BYTE_W-1:0]   text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

>>> rtl/stok_token_if.sv
`timescale 1ns / 1ps

// Token channel: one token or error per word.
interface stok_token_if;
	logic                          valid;
	logic                          ready;
	logic [stok_pkg::KIND_W-1:0]   token_kind;
	logic [stok_pkg::FIELD_W-1:0]  token_start;
	logic [stok_pkg::FIELD_W-1:0]  token_length;
	logic [stok_pkg::ERR_W-1:0]    error_code;
	logic                          last_in_run;

	modport source(output valid, output token_kind, output token_start, output token_length,
		output error_code, output last_in_run, input ready);
	modport sink(input valid, input token_kind, input token_start, input token_length,
		input error_code, input last_in_run, output ready);
endinterface

>>> rtl/source_tokenizer_core.sv
`timescale 1ns / 1ps

// Streaming maximal-munch tokenizer. Source text arrives one byte per word on the text
// channel, with byte 0 ending a text; tokens (keywords, identifiers, integers, strings,
// one- and two-character operators, errors and the end token) leave on the tokens channel
// with kind, start position, length and error code. A byte is scanned in the cycle it is
// accepted and its zero, one or two tokens go into a four-word output queue, so the block
// takes one byte per cycle as long as the queue has two free words. The queue drains one
// token per cycle while the receiver is ready, which sets the sustained rate: a byte that
// closes one token and opens another (for example "a;") queues two tokens. A byte's tokens
// are registered in the queue before output. After an error, bytes are dropped up to the
// next byte 0, which always yields the end token and restarts the position at zero.
module source_tokenizer_core #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_COUNT = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	stok_byte_if.sink    text,
	stok_token_if.source tokens
);

	// Scan modes.
	typedef enum logic [11:0] {
		M_IDLE  = 12'b0000_0000_0001,
		M_IDENT = 12'b0000_0000_0010,
		M_NUM   = 12'b0000_0000_0100,
		M_BADID = 12'b0000_0000_1000,
		M_STR   = 12'b0000_0001_0000,
		M_ESC   = 12'b0000_0010_0000,
		M_COLON = 12'b0000_0100_0000,
		M_EQ    = 12'b0000_1000_0000,
		M_BANG  = 12'b0001_0000_0000,
		M_LT    = 12'b0010_0000_0000,
		M_GT    = 12'b0100_0000_0000,
		M_ERROR = 12'b1000_0000_0000
	} mode_t;

	localparam logic [KEYWORD_COUNT-1:0] CAND_ALL = '1;
	localparam int QDEPTH = 4;

	// Scanner state.
	mode_t                          mode_q, mode_d;
	logic [POSITION_BITS-1:0]       pos_q, pos_d;
	logic [POSITION_BITS-1:0]       begin_q, begin_d;
	logic [KEYWORD_COUNT-1:0]       cand_q, cand_d;
	logic [stok_pkg::FIELD_W-1:0]   len_q, len_d;

	// Output queue.
	stok_pkg::result_t              queue_q [QDEPTH];
	logic [1:0]                     head_q, tail_q;
	logic [2:0]                     count_q;

	logic [stok_pkg::BYTE_W-1:0]    b;
	logic                           in_fire, out_fire;
	logic [stok_pkg::FIELD_W-1:0]   pos16, begin16, len_inc;
	logic [KEYWORD_COUNT-1:0]       cand_word, cand_first;
	logic [stok_pkg::KIND_W-1:0]    word_kind;

	// Results of scanning the byte as the first byte of a new token.
	mode_t                          i_mode;
	logic                           i_emit;
	stok_pkg::result_t              i_res;
	logic [KEYWORD_COUNT-1:0]       i_cand;

	stok_pkg::result_t              r0, r1;
	logic [1:0]                     n_res, push_n;

	assign b = text.text_byte;
	assign in_fire = text.valid && text.ready;
	assign out_fire = tokens.valid && tokens.ready;
	assign pos16 = stok_pkg::FIELD_W'(pos_q);
	assign begin16 = stok_pkg::FIELD_W'(begin_q);
	assign len_inc = (len_q == '1) ? len_q : len_q + 16'd1;

	// Keyword candidate narrowing and word classification.
	always_comb begin
		cand_word = cand_q;
		cand_first = CAND_ALL;
		word_kind = stok_pkg::KIND_IDENT;
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			if (len_q >= stok_pkg::FIELD_W'(stok_pkg::KW_LEN[i]) ||
					stok_pkg::KW_TEXT[i][len_q[2:0]] != b) begin
				cand_word[i] = 1'b0;
			end
			if (stok_pkg::KW_TEXT[i][0] != b) begin
				cand_first[i] = 1'b0;
			end
		end
		// The lowest matching keyword wins, so scan from the top down.
		for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
			if (cand_q[i] && len_q == stok_pkg::FIELD_W'(stok_pkg::KW_LEN[i])) begin
				word_kind = stok_pkg::KIND_W'(i);
			end
		end
	end

	// Scan the byte as the start of a new token.
	always_comb begin
		i_mode = M_IDLE;
		i_emit = 1'b0;
		i_res = stok_pkg::mk_res(stok_pkg::KIND_END, pos16, '0, stok_pkg::ERR_NONE);
		i_cand = cand_q;
		if (b == stok_pkg::CH_NUL) begin
			i_emit = 1'b1;
		end else if (stok_pkg::is_space(b)) begin
			i_mode = M_IDLE;
		end else if (stok_pkg::is_alpha(b) || b == stok_pkg::CH_UNDERSCORE) begin
			i_mode = M_IDENT;
			i_cand = cand_first;
		end else if (stok_pkg::is_digit(b)) begin
			i_mode = M_NUM;
		end else begin
			case (b)
				stok_pkg::CH_QUOTE:   i_mode = M_STR;
				stok_pkg::CH_COLON:   i_mode = M_COLON;
				stok_pkg::CH_EQUAL:   i_mode = M_EQ;
				stok_pkg::CH_BANG:    i_mode = M_BANG;
				stok_pkg::CH_LESS:    i_mode = M_LT;
				stok_pkg::CH_GREATER: i_mode = M_GT;
				stok_pkg::CH_SEMI: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_SEMI, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_COMMA: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_COMMA, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_LPAREN: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_LPAREN, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_RPAREN: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_RPAREN, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_LBRACE: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_LBRACE, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_RBRACE: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_RBRACE, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_PLUS: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_PLUS, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_MINUS: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_MINUS, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				stok_pkg::CH_STAR: begin
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_STAR, pos16, 16'd1, stok_pkg::ERR_NONE);
				end
				default: begin
					i_mode = M_ERROR;
					i_emit = 1'b1;
					i_res = stok_pkg::mk_res(stok_pkg::KIND_ERR, pos16, 16'd1,
						stok_pkg::ERR_INVALID);
				end
			endcase
		end
	end

	// Main scanner: next state and up to two tokens for the byte.
	always_comb begin
		mode_d = mode_q;
		begin_d = begin_q;
		len_d = len_q;
		cand_d = cand_q;
		r0 = stok_pkg::mk_res(stok_pkg::KIND_END, pos16, '0, stok_pkg::ERR_NONE);
		r1 = r0;
		n_res = 2'd0;

		case (mode_q)
			M_IDENT: begin
				if (stok_pkg::is_word(b)) begin
					cand_d = cand_word;
					len_d = len_inc;
				end else begin
					r0 = stok_pkg::mk_res(word_kind, begin16, len_q, stok_pkg::ERR_NONE);
					n_res = 2'd1;
				end
			end
			M_NUM: begin
				if (stok_pkg::is_digit(b)) begin
					len_d = len_inc;
				end else if (stok_pkg::is_alpha(b) || b == stok_pkg::CH_UNDERSCORE) begin
					len_d = len_inc;
					mode_d = M_BADID;
				end else begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_INT, begin16, len_q, stok_pkg::ERR_NONE);
					n_res = 2'd1;
				end
			end
			M_BADID: begin
				if (stok_pkg::is_word(b)) begin
					len_d = len_inc;
				end else begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_ERR, begin16, len_q,
						stok_pkg::ERR_DIGITID);
					n_res = 2'd1;
					mode_d = M_ERROR;
				end
			end
			M_STR, M_ESC: begin
				if (b == stok_pkg::CH_NUL) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_ERR, begin16, len_q,
						stok_pkg::ERR_INVALID);
					n_res = 2'd1;
					mode_d = M_ERROR;
				end else begin
					len_d = len_inc;
					if (mode_q == M_ESC) begin
						mode_d = M_STR;
					end else if (b == stok_pkg::CH_BACKSLASH) begin
						mode_d = M_ESC;
					end else if (b == stok_pkg::CH_QUOTE) begin
						r0 = stok_pkg::mk_res(stok_pkg::KIND_STR, begin16, len_inc,
							stok_pkg::ERR_NONE);
						n_res = 2'd1;
						mode_d = M_IDLE;
					end
				end
			end
			M_COLON: begin
				n_res = 2'd1;
				mode_d = M_IDLE;
				if (b == stok_pkg::CH_COLON) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_COLON2, begin16, 16'd2,
						stok_pkg::ERR_NONE);
				end else if (b == stok_pkg::CH_EQUAL) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_ASSIGN, begin16, 16'd2,
						stok_pkg::ERR_NONE);
				end else begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_ERR, begin16, len_q,
						stok_pkg::ERR_COLON);
					mode_d = M_ERROR;
				end
			end
			M_BANG: begin
				n_res = 2'd1;
				if (b == stok_pkg::CH_EQUAL) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_NE, begin16, 16'd2, stok_pkg::ERR_NONE);
					mode_d = M_IDLE;
				end else begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_ERR, begin16, len_q,
						stok_pkg::ERR_BANG);
					mode_d = M_ERROR;
				end
			end
			M_EQ, M_LT, M_GT: begin
				n_res = 2'd1;
				if (b == stok_pkg::CH_EQUAL) begin
					mode_d = M_IDLE;
					if (mode_q == M_EQ) begin
						r0 = stok_pkg::mk_res(stok_pkg::KIND_EQEQ, begin16, 16'd2,
							stok_pkg::ERR_NONE);
					end else if (mode_q == M_LT) begin
						r0 = stok_pkg::mk_res(stok_pkg::KIND_LE, begin16, 16'd2,
							stok_pkg::ERR_NONE);
					end else begin
						r0 = stok_pkg::mk_res(stok_pkg::KIND_GE, begin16, 16'd2,
							stok_pkg::ERR_NONE);
					end
				end else if (mode_q == M_EQ) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_EQ, begin16, 16'd1, stok_pkg::ERR_NONE);
				end else if (mode_q == M_LT) begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_LT, begin16, 16'd1, stok_pkg::ERR_NONE);
				end else begin
					r0 = stok_pkg::mk_res(stok_pkg::KIND_GT, begin16, 16'd1, stok_pkg::ERR_NONE);
				end
			end
			M_ERROR: begin
				if (b == stok_pkg::CH_NUL) begin
					n_res = 2'd1;
				end
			end
			default: begin
				// Idle: the byte is scanned as the start of a new token.
				mode_d = i_mode;
				begin_d = pos_q;
				len_d = 16'd1;
				cand_d = i_cand;
				if (i_emit) begin
					r0 = i_res;
					n_res = 2'd1;
				end
			end
		endcase

		// A byte that ended the current token without belonging to it starts the next one.
		if (n_res == 2'd1 && mode_d == mode_q && mode_q != M_ERROR && mode_q != M_IDLE) begin
			mode_d = i_mode;
			begin_d = pos_q;
			len_d = 16'd1;
			cand_d = i_cand;
			if (i_emit) begin
				r1 = i_res;
				n_res = 2'd2;
			end
		end else if (n_res == 2'd1 && mode_d == M_ERROR && mode_q != M_ERROR &&
				mode_q != M_IDLE && b == stok_pkg::CH_NUL) begin
			// An error closed by byte 0 is followed by the end token.
			n_res = 2'd2;
		end

		// Byte 0 returns the scanner to the start of a fresh text.
		if (b == stok_pkg::CH_NUL) begin
			mode_d = M_IDLE;
			pos_d = '0;
			cand_d = CAND_ALL;
			len_d = '0;
		end else begin
			pos_d = pos_q + 1'b1;
		end

		if (n_res == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0;
			begin_q <= '0;
			cand_q <= CAND_ALL;
			len_q <= '0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			begin_q <= begin_d;
			cand_q <= cand_d;
			len_q <= len_d;
		end
	end

	// Output queue control: a byte is taken only while at least two words are free.
	assign push_n = in_fire ? n_res : 2'd0;
	assign text.ready = (count_q <= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			tail_q <= tail_q + push_n;
			head_q <= head_q + 2'(out_fire);
			count_q <= count_q + 3'(push_n) - 3'(out_fire);
		end
	end

	// Output queue storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[tail_q] <= r0;
		end
		if (push_n == 2'd2) begin
			queue_q[tail_q + 2'd1] <= r1;
		end
	end

	assign tokens.valid = (count_q != 3'd0);
	assign tokens.token_kind = queue_q[head_q].kind;
	assign tokens.token_start = queue_q[head_q].start;
	assign tokens.token_length = queue_q[head_q].length;
	assign tokens.error_code = queue_q[head_q].err;
	assign tokens.last_in_run = queue_q[head_q].last;

`ifndef SYNTH
	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("token queue overflow");

	// Byte 0 always closes its run with the end token.
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && b == stok_pkg::CH_NUL) |->
			((push_n == 2'd1 && r0.kind == stok_pkg::KIND_END) ||
			 (push_n == 2'd2 && r1.kind == stok_pkg::KIND_END)))
		else $error("byte 0 did not yield the end token");

	// After byte 0 the scanner restarts at position zero in idle mode.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && b == stok_pkg::CH_NUL) |=> (pos_q == '0 && mode_q == M_IDLE))
		else $error("scanner did not restart after end of text");

	// After an error, bytes other than 0 give no token.
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_q == M_ERROR && b != stok_pkg::CH_NUL) |-> (push_n == 2'd0))
		else $error("token emitted while skipping after an error");
`endif

endmodule
